[hw/rtl/gyro_rotation_dial_integrator_assert.svh]
// Assertion shorthands for the gyro dial integrator.
// Both expect clk and rst_n in scope.
`ifndef GYRO_ROTATION_DIAL_INTEGRATOR_ASSERT_SVH
`define GYRO_ROTATION_DIAL_INTEGRATOR_ASSERT_SVH

// Same-cycle implication.
`define GRDI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GRDI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/grdi_pkg.sv]
package grdi_pkg;

    // Field widths
    localparam int GYRO_W   = 16;
    localparam int DT_W     = 20;
    localparam int CODE_W   = 12;
    localparam int DIAL_W   = 8;
    localparam int RATE_W   = GYRO_W + 1;
    localparam int MAG_W    = GYRO_W;
    localparam int PROD_W   = MAG_W + DT_W;
    localparam int ACC_W    = 40;
    localparam int BAND_W   = 15;
    localparam int TICK_W   = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_RATE_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIAL_MAX    = 3'd3;

    localparam logic signed [GYRO_W-1:0] RST_RATE_OFFSET = 16'sd0;
    localparam logic [BAND_W-1:0]        RST_DEAD_BAND   = 15'd66;
    localparam logic [TICK_W-1:0]        RST_TICK_SIZE   = 32'd471600000;
    localparam logic [DIAL_W-1:0]        RST_DIAL_MAX    = 8'd100;

    // Serial step counts
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(DT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W - 1);

endpackage

[hw/rtl/gyro_rotation_dial_integrator.sv]
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  gyro_raw, elapsed_us, level_code, threshold_code
// out       source     out_valid / out_stall dial_value, engaged
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Engaged sample: the 20-step shift-add multiplier over elapsed_us, then the 40-step
// restoring divider by tick_size, then the output register.
// Disengaged sample: skips both and goes straight to the output register. One sample is worked on at a time.
// rst_n is asynchronous; it clears state and the output valid and loads the configuration defaults.
// A stalled result holds; the next sample is taken meanwhile and finishes once the
// output register frees up. cfg_ready is always high.
module gyro_rotation_dial_integrator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [grdi_pkg::GYRO_W-1:0]    gyro_raw,
    input  logic [grdi_pkg::DT_W-1:0]             elapsed_us,
    input  logic [grdi_pkg::CODE_W-1:0]           level_code,
    input  logic [grdi_pkg::CODE_W-1:0]           threshold_code,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [grdi_pkg::DIAL_W-1:0]           dial_value,
    output logic                                  engaged,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [grdi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [grdi_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import grdi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_SUM,
        S_ABS,
        S_DIV,
        S_FIX,
        S_DONE
    } state_t;

    state_t state_reg;

    logic signed [GYRO_W-1:0] rate_offset_reg;
    logic [BAND_W-1:0]        dead_band_reg;
    logic [TICK_W-1:0]        tick_size_reg;
    logic [DIAL_W-1:0]        dial_max_reg;

    logic signed [ACC_W-1:0]  accum_reg;
    logic [DIAL_W-1:0]        dial_pos_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     on_reg;
    logic                     out_valid_reg;
    logic [DIAL_W-1:0]        dial_out_reg;
    logic                     engaged_out_reg;

    // Datapath, no reset
    logic signed [RATE_W-1:0] rate_reg;
    logic                     rate_neg_reg;
    logic [MAG_W-1:0]         mcand_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [ACC_W-1:0]         dvd_reg;
    logic                     sum_neg_reg;
    logic [TICK_W-1:0]        rem_reg;
    logic [TICK_W-1:0]        div_reg;

    logic in_accept;
    logic out_free;

    logic signed [RATE_W-1:0] rate_next;
    logic [RATE_W-1:0]        rate_mag;
    logic [MAG_W:0]           mul_sum;
    logic [PROD_W-1:0]        prod_next;
    logic [ACC_W-1:0]         prod_wide;
    logic [ACC_W-1:0]         sum_next;
    logic [ACC_W-1:0]         abs_next;
    logic [TICK_W:0]          div_shift;
    logic [TICK_W+1:0]        div_diff;
    logic                     div_ge;
    logic [ACC_W-1:0]         rem_wide;
    logic signed [ACC_W-1:0]  accum_next;
    logic [ACC_W:0]           dial_up;
    logic [DIAL_W-1:0]        dial_down;
    logic [DIAL_W-1:0]        dial_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign dial_value = dial_out_reg;
    assign engaged    = engaged_out_reg;

    always_comb
    begin
        rate_next = RATE_W'(rate_offset_reg) - RATE_W'(gyro_raw);
        rate_mag  = rate_reg[RATE_W-1] ? RATE_W'(-rate_reg) : RATE_W'(rate_reg);

        // Shift-add: add the multiplicand into the high half on a set LSB, shift right
        mul_sum   = {1'b0, prod_reg[PROD_W-1:DT_W]}
                  + (prod_reg[0] ? {1'b0, mcand_reg} : {(MAG_W+1){1'b0}});
        prod_next = {mul_sum, prod_reg[DT_W-1:1]};

        prod_wide = ACC_W'(prod_reg);
        sum_next  = rate_neg_reg ? (ACC_W'(accum_reg) - prod_wide)
                                 : (ACC_W'(accum_reg) + prod_wide);
        abs_next  = dvd_reg[ACC_W-1] ? (~dvd_reg + 1'b1) : dvd_reg;

        div_shift = {rem_reg, dvd_reg[ACC_W-1]};
        div_diff  = {1'b0, div_shift} - {2'b00, div_reg};
        div_ge    = !div_diff[TICK_W+1];

        // Remainder keeps the sign of the dividend
        rem_wide   = ACC_W'(rem_reg);
        accum_next = sum_neg_reg ? $signed(~rem_wide + 1'b1) : $signed(rem_wide);

        dial_up   = {{(ACC_W+1-DIAL_W){1'b0}}, dial_pos_reg} + {1'b0, dvd_reg};
        dial_down = (dvd_reg > ACC_W'(dial_pos_reg)) ? '0
                                                     : (dial_pos_reg - dvd_reg[DIAL_W-1:0]);
        if (sum_neg_reg)
        begin
            dial_next = (dial_down > dial_max_reg) ? dial_max_reg : dial_down;
        end
        else
        begin
            dial_next = (dial_up > (ACC_W+1)'(dial_max_reg)) ? dial_max_reg
                                                              : dial_up[DIAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rate_offset_reg <= RST_RATE_OFFSET;
            dead_band_reg   <= RST_DEAD_BAND;
            tick_size_reg   <= RST_TICK_SIZE;
            dial_max_reg    <= RST_DIAL_MAX;
            accum_reg       <= '0;
            dial_pos_reg    <= '0;
            cnt_reg         <= '0;
            on_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            dial_out_reg    <= '0;
            engaged_out_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RATE_OFFSET: rate_offset_reg <= cfg_data[GYRO_W-1:0];
                    REG_DEAD_BAND:   dead_band_reg   <= cfg_data[BAND_W-1:0];
                    REG_TICK_SIZE:   tick_size_reg   <= cfg_data[TICK_W-1:0];
                    REG_DIAL_MAX:    dial_max_reg    <= cfg_data[DIAL_W-1:0];
                    default:         ;
                endcase
            end

            // Drop a taken result unless the next one loads in the same cycle
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        on_reg <= (level_code > threshold_code);
                        if (level_code > threshold_code)
                        begin
                            state_reg <= S_PREP;
                        end
                        else
                        begin
                            accum_reg <= '0;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_PREP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == MUL_LAST)
                    begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    state_reg <= S_ABS;
                end
                S_ABS:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        state_reg <= S_FIX;
                    end
                end
                S_FIX:
                begin
                    accum_reg    <= accum_next;
                    dial_pos_reg <= dial_next;
                    state_reg    <= S_DONE;
                end
                S_DONE:
                begin
                    // Hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        dial_out_reg    <= dial_pos_reg;
                        engaged_out_reg <= on_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    rate_reg <= rate_next;
                    prod_reg <= {{MAG_W{1'b0}}, elapsed_us};
                end
            end
            S_PREP:
            begin
                rate_neg_reg <= rate_reg[RATE_W-1];
                // Strict deadband: magnitudes below the band count as zero
                mcand_reg <= (rate_mag < RATE_W'(dead_band_reg)) ? '0 : rate_mag[MAG_W-1:0];
            end
            S_MUL:
            begin
                prod_reg <= prod_next;
            end
            S_SUM:
            begin
                dvd_reg <= sum_next;
            end
            S_ABS:
            begin
                sum_neg_reg <= dvd_reg[ACC_W-1];
                dvd_reg     <= abs_next;
                rem_reg     <= '0;
                div_reg     <= (tick_size_reg == '0) ? TICK_W'(1) : tick_size_reg;
            end
            S_DIV:
            begin
                // Quotient bits shift in where dividend bits leave
                rem_reg <= div_ge ? div_diff[TICK_W-1:0] : div_shift[TICK_W-1:0];
                dvd_reg <= {dvd_reg[ACC_W-2:0], div_ge};
            end
            default:
            begin
            end
        endcase
    end

endmodule

[hw/rtl/grdi_checker.sv]
`include "gyro_rotation_dial_integrator_assert.svh"

module grdi_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [grdi_pkg::DIAL_W-1:0] dial_value,
    input logic                        engaged,
    input logic                        cfg_valid,
    input logic                        cfg_ready
);
    import grdi_pkg::*;

    // A stalled result keeps its payload
    `GRDI_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(dial_value) && $stable(engaged), "stalled result changed")

    // One sample at a time: busy right after a transaction
    `GRDI_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "input taken while a sample is still in flight")

    // A new result shows up only from a busy block
    `GRDI_ASSERT_IMP(a_result_from_work, out_valid && !$past(out_valid),
        $past(in_stall), "result appeared without a sample in flight")

    // Configuration is never back-pressured
    `GRDI_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind gyro_rotation_dial_integrator grdi_checker u_grdi_checker (.*);
